// ===== rtl/core/wsd_pkg.sv =====
package wsd_pkg;

  // Width kept of a frame's remaining length (16 to 64).
  localparam int LengthBits = 64;

  // Length codes of byte 1.
  localparam logic [6:0] LenCodeMaxShort = 7'd125;
  localparam logic [6:0] LenCode16 = 7'd126;

  // Extended length bytes for each form, and mask key bytes.
  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;
  localparam logic [3:0] MaskBytes = 4'd4;

  localparam logic [3:0] OpcodeClose = 4'h8;

  typedef enum logic [2:0] {
    PH_BYTE0,
    PH_BYTE1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_RSV_ERR = 2'd2,
    KIND_TRUNC   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       buffer_end;
  } in_word_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       is_close;
    logic       frame_last;
  } out_word_t;

  // One parse step handed from the input register to the parser.
  typedef struct packed {
    logic     en;
    in_word_t word;
  } step_t;

endpackage

// ===== rtl/core/websocket_frame_deframer_top.sv =====
// Channel  | Direction | Handshake                     | Word
// stream   | in        | stream_valid / stream_ready   | stream_data (in_word_t)
// result   | out       | result_valid / result_ready   | result_data (out_word_t)
//
// Each byte is parsed while it sits in the input register; its result, if any,
// lands in the output register at the next edge, so one byte per cycle is
// sustained while results are taken. The 64-bit length decrement sets
// the critical path. Reset (rst, synchronous) empties both registers and sends
// the parser back to the first header byte; a reserved-bit error halts it.
// stream_ready drops only while both registers are full and the result waits.
module websocket_frame_deframer_top
  import wsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      stream_valid,
  output logic      stream_ready,
  input  in_word_t  stream_data,
  output logic      result_valid,
  input  logic      result_ready,
  output out_word_t result_data
);

  // Input register.
  logic     s1_valid;
  in_word_t s1_word;

  // Parser step and its result.
  step_t     step;
  logic      step_res_valid;
  out_word_t step_res;
  logic      out_free;

  // The output register can take a new result when it is empty or being read
  // this cycle; a parse step happens only then, so no result is ever dropped.
  assign out_free     = !result_valid || result_ready;
  assign step.en      = s1_valid && out_free;
  assign step.word    = s1_word;
  assign stream_ready = !s1_valid || step.en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream_valid && stream_ready) begin
      s1_valid <= 1'b1;
    end else if (step.en) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream_valid && stream_ready) begin
      s1_word <= stream_data;
    end
  end

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .res_valid (step_res_valid),
    .res       (step_res)
  );

  // Output register. A byte that produces no result simply empties the slot
  // if it was being read.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step.en) begin
      result_valid <= step_res_valid;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.en && step_res_valid) begin
      result_data <= step_res;
    end
  end

endmodule

// ===== rtl/core/wsd_parser.sv =====
module wsd_parser
  import wsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  step_t     step,
  output logic      res_valid,
  output out_word_t res
);

  phase_t                 phase, phase_next;
  logic [3:0]             header_count, header_count_next;
  logic [3:0]             held_opcode, held_opcode_next;
  logic [LengthBits-1:0]  remaining, remaining_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [1:0]             mask_index, mask_index_next;
  logic                   halted, halted_next;
  logic                   ext_long, ext_long_next;

  logic [7:0] b;
  logic       chunk_end;
  logic [3:0] count_inc;
  logic [3:0] ext_needed;
  logic [7:0] key_byte;
  logic       rsv_hit;
  logic       pay_done;
  logic       empty_done;
  logic       mask_last;
  logic       frame_done;
  logic       trunc;

  assign b          = step.word.stream_byte;
  assign chunk_end  = step.word.buffer_end;
  assign count_inc  = header_count + 4'd1;
  assign ext_needed = ext_long ? ExtBytes64 : ExtBytes16;
  assign key_byte   = mask_key[31 - 8 * mask_index -: 8];

  assign rsv_hit    = (phase == PH_BYTE0) && b[6];
  assign mask_last  = (phase == PH_MASK) && (count_inc >= MaskBytes);
  assign empty_done = mask_last && (remaining == '0);
  assign pay_done   = (phase == PH_PAYLOAD) &&
                      (remaining == LengthBits'(1));
  assign frame_done = pay_done || empty_done;
  assign trunc      = chunk_end && !frame_done && !rsv_hit;

  // Next state.
  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    held_opcode_next  = held_opcode;
    remaining_next    = remaining;
    mask_key_next     = mask_key;
    mask_index_next   = mask_index;
    halted_next       = halted;
    ext_long_next     = ext_long;
    if (step.en && !halted) begin
      unique case (phase)
        PH_BYTE0: begin
          held_opcode_next = b[3:0];
          if (rsv_hit) begin
            halted_next = 1'b1;
          end else begin
            phase_next = PH_BYTE1;
          end
        end
        PH_BYTE1: begin
          header_count_next = '0;
          mask_key_next     = '0;
          mask_index_next   = '0;
          if (b[6:0] <= LenCodeMaxShort) begin
            remaining_next = LengthBits'(b[6:0]);
            phase_next     = PH_MASK;
          end else begin
            remaining_next = '0;
            ext_long_next  = (b[6:0] != LenCode16);
            phase_next     = PH_EXTLEN;
          end
        end
        PH_EXTLEN: begin
          remaining_next    = {remaining[LengthBits-9:0], b};
          header_count_next = count_inc;
          if (count_inc >= ext_needed) begin
            header_count_next = '0;
            phase_next        = PH_MASK;
          end
        end
        PH_MASK: begin
          mask_key_next     = {mask_key[23:0], b};
          header_count_next = count_inc;
          if (mask_last) begin
            header_count_next = '0;
            phase_next        = (remaining == '0) ? PH_BYTE0 : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          remaining_next  = remaining - LengthBits'(1);
          mask_index_next = mask_index + 2'd1;
          if (pay_done) begin
            phase_next = PH_BYTE0;
          end
        end
        default: begin
          phase_next = PH_BYTE0;
        end
      endcase
      // A finished frame or a cut chunk both return to header parsing.
      if (frame_done || trunc) begin
        phase_next        = PH_BYTE0;
        header_count_next = '0;
        remaining_next    = '0;
        mask_index_next   = '0;
      end
    end
  end

  // Outputs.
  always_comb begin
    res_valid        = 1'b0;
    res.kind         = KIND_PAYLOAD;
    res.payload_byte = '0;
    res.frame_opcode = held_opcode;
    res.frame_last   = 1'b1;
    if (step.en && !halted) begin
      unique case (phase)
        PH_BYTE0: begin
          res.frame_opcode = b[3:0];
          if (rsv_hit) begin
            res_valid = 1'b1;
            res.kind  = KIND_RSV_ERR;
          end
        end
        PH_MASK: begin
          if (empty_done) begin
            res_valid = 1'b1;
            res.kind  = KIND_EMPTY;
          end
        end
        PH_PAYLOAD: begin
          res_valid        = 1'b1;
          res.payload_byte = b ^ key_byte;
          res.frame_last   = pay_done;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
      if (trunc) begin
        res_valid        = 1'b1;
        res.kind         = KIND_TRUNC;
        res.payload_byte = '0;
        res.frame_last   = 1'b1;
      end
    end
    res.is_close = (res.frame_opcode == OpcodeClose);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_BYTE0;
      header_count <= '0;
      held_opcode  <= '0;
      remaining    <= '0;
      mask_key     <= '0;
      mask_index   <= '0;
      halted       <= 1'b0;
      ext_long     <= 1'b0;
    end else begin
      phase        <= phase_next;
      header_count <= header_count_next;
      held_opcode  <= held_opcode_next;
      remaining    <= remaining_next;
      mask_key     <= mask_key_next;
      mask_index   <= mask_index_next;
      halted       <= halted_next;
      ext_long     <= ext_long_next;
    end
  end

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted flag cleared without reset");

  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.kind == KIND_RSV_ERR)) |=> halted)
    else $error("reserved-bit error did not halt the parser");

  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (remaining != '0))
    else $error("payload phase with zero remaining length");

  a_mask_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_MASK) |-> (header_count < MaskBytes))
    else $error("mask key byte count out of range");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (step.en && !halted && (frame_done || trunc)) |=>
      ((phase == PH_BYTE0) && (header_count == '0) && (mask_index == '0)))
    else $error("frame end did not return to header parsing");

endmodule

// ===== bench/wsd_result_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the deframer, predicts the result word, if any, of
// every accepted stream word and compares the results in order, field by field.
module wsd_result_checker
  import wsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      stream_valid,
  input  logic      stream_ready,
  input  in_word_t  stream_data,
  input  logic      result_valid,
  input  logic      result_ready,
  input  out_word_t result_data,
  output int        errors,
  output int        outstanding,
  output int        checked
);

  // Parser state as the block keeps it.
  phase_t                phase;
  logic [3:0]            hdr_count;
  logic [3:0]            ext_needed;
  logic [3:0]            opcode;
  logic [LengthBits-1:0] remaining;
  logic [31:0]           mask_key;
  logic [1:0]            mask_idx;
  logic                  halted;

  out_word_t predicted_words[$];
  int        mistakes;
  int        seen;

  assign errors  = mistakes;
  assign checked = seen;

  function automatic out_word_t result_word(input kind_t k, input logic [7:0] data,
                                            input logic [3:0] op, input logic last);
    out_word_t w;
    w.kind         = k;
    w.payload_byte = data;
    w.frame_opcode = op;
    w.is_close     = (op == OpcodeClose);
    w.frame_last   = last;
    return w;
  endfunction

  task automatic back_to_header();
    phase     = PH_BYTE0;
    hdr_count = '0;
    remaining = '0;
    mask_idx  = '0;
  endtask

  // Advances the parser by one stream word and queues the result it causes.
  task automatic deframe_word(input in_word_t w);
    logic [7:0] b;
    logic [7:0] key_byte;
    logic       frame_done;
    logic       has_result;
    out_word_t  r;
    b          = w.stream_byte;
    frame_done = 1'b0;
    has_result = 1'b0;
    r          = '0;
    if (halted) return;
    case (phase)
      PH_BYTE0: begin
        opcode = b[3:0];
        // RSV1 wins over a chunk end on the same word, and stops the parser.
        if (b[6]) begin
          predicted_words.push_back(result_word(KIND_RSV_ERR, 8'h00, opcode, 1'b1));
          halted = 1'b1;
          return;
        end
        phase = PH_BYTE1;
      end
      PH_BYTE1: begin
        hdr_count = '0;
        mask_key  = '0;
        mask_idx  = '0;
        if (b[6:0] <= LenCodeMaxShort) begin
          remaining = LengthBits'(b[6:0]);
          phase     = PH_MASK;
        end else begin
          remaining  = '0;
          ext_needed = (b[6:0] == LenCode16) ? ExtBytes16 : ExtBytes64;
          phase      = PH_EXTLEN;
        end
      end
      PH_EXTLEN: begin
        remaining = (remaining << 8) | LengthBits'(b);
        hdr_count = hdr_count + 4'd1;
        if (hdr_count >= ext_needed) begin
          hdr_count = '0;
          phase     = PH_MASK;
        end
      end
      PH_MASK: begin
        mask_key  = {mask_key[23:0], b};
        hdr_count = hdr_count + 4'd1;
        if (hdr_count >= MaskBytes) begin
          hdr_count = '0;
          if (remaining == '0) begin
            r          = result_word(KIND_EMPTY, 8'h00, opcode, 1'b1);
            has_result = 1'b1;
            frame_done = 1'b1;
            back_to_header();
          end else begin
            phase = PH_PAYLOAD;
          end
        end
      end
      default: begin
        key_byte   = mask_key[8 * (3 - mask_idx) +: 8];
        remaining  = remaining - 1'b1;
        mask_idx   = mask_idx + 2'd1;
        frame_done = (remaining == '0);
        if (frame_done || !w.buffer_end) begin
          r          = result_word(KIND_PAYLOAD, b ^ key_byte, opcode, frame_done);
          has_result = 1'b1;
        end
        if (frame_done) back_to_header();
      end
    endcase
    if (w.buffer_end && !frame_done) begin
      r          = result_word(KIND_TRUNC, 8'h00, opcode, 1'b1);
      has_result = 1'b1;
      back_to_header();
    end
    if (has_result) predicted_words.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mistakes++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      back_to_header();
      opcode     = '0;
      mask_key   = '0;
      ext_needed = '0;
      halted     = 1'b0;
      mistakes   = 0;
      seen       = 0;
      predicted_words.delete();
    end else begin
      // Results first: a word accepted at this edge cannot have caused one yet.
      if (result_valid && result_ready) begin
        seen++;
        if (predicted_words.size() == 0) begin
          mistakes++;
          $display("%0t: result word with nothing expected:", $time);
          $display("  kind %0d byte %02h op %0h close %0b last %0b",
                   result_data.kind, result_data.payload_byte,
                   result_data.frame_opcode, result_data.is_close, result_data.frame_last);
        end else begin
          want = predicted_words.pop_front();
          check_field("kind", want.kind, result_data.kind);
          check_field("payload_byte", want.payload_byte, result_data.payload_byte);
          check_field("frame_opcode", want.frame_opcode, result_data.frame_opcode);
          check_field("is_close", want.is_close, result_data.is_close);
          check_field("frame_last", want.frame_last, result_data.frame_last);
        end
      end
      if (stream_valid && stream_ready) deframe_word(stream_data);
    end
    outstanding <= predicted_words.size();
  end

endmodule

// ===== bench/websocket_frame_deframer_top_tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the WebSocket deframer. Frames are built whole here
// (header, extended length, mask key and random payload) and fed one word at a
// time; the checker beside the block predicts and compares every result word.
module websocket_frame_deframer_top_tb;
  import wsd_pkg::*;

  // Byte 1 code that announces a 64-bit extended length.
  localparam logic [6:0] LenCode64 = 7'd127;

  // Rough number of stream words in the random part.
  localparam int RandomWords = 1850;

  // The longest honest quiet stretch is a sender gap on top of a receiver
  // stall; this allows many times that before giving up.
  localparam int QuietLimit = 2000;

  // Cycles to watch after the last expected result for stray result words.
  localparam int DrainCycles = 16;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      stream_valid = 1'b0;
  logic      stream_ready;
  in_word_t  stream_data = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_word_t result_data;

  int errors;
  int outstanding;
  int checked;

  // Sender bookkeeping and run statistics.
  int burst_left = 0;
  int words_sent = 0;
  int frames_sent = 0;
  int frames_cut = 0;
  int frames_ext16 = 0;
  int frames_ext64 = 0;

  // Receiver stall pattern state.
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_stall_left = 0;

  int quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  websocket_frame_deframer_top DUT (
    .clk          (clk),
    .rst          (rst),
    .stream_valid (stream_valid),
    .stream_ready (stream_ready),
    .stream_data  (stream_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  wsd_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .stream_valid (stream_valid),
    .stream_ready (stream_ready),
    .stream_data  (stream_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .errors       (errors),
    .outstanding  (outstanding),
    .checked      (checked)
  );

  // The receiver switches at random between four moods: always
  // ready, and three levels of stalling with longer and more frequent stalls.
  // Mood zero gives long stretches in which the result channel never stalls.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(50, 300);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    if (rx_stall_left != 0) begin
      result_ready  <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_mode != 0 && $urandom_range(0, 7) < 2 * rx_mode - 1) begin
      result_ready  <= 1'b0;
      rx_stall_left <= $urandom_range(0, 5 * rx_mode - 1);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Watchdog: a run in which no word moves on either channel for too long is
  // a hang, whatever its cause.
  always @(posedge clk) begin
    if (rst || (stream_valid && stream_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Watchdog: no word moved for %0d cycles at %0t", quiet_cycles, $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one stream word and returns at the edge that accepts it. The sender
  // works in bursts; between bursts it may drop valid for a random gap. Valid
  // is only lowered at the start of a gap, so it is never lowered and raised
  // again within one time step.
  task automatic send_word(input logic [7:0] data, input logic chunk_end);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      if (gap != 0) begin
        stream_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    stream_valid <= 1'b1;
    stream_data  <= '{stream_byte: data, buffer_end: chunk_end};
    @(posedge clk);
    while (!stream_ready) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  // Sends one client frame. The length code picks the form of the extended
  // length, which goes out big-endian, followed by the four mask key bytes and
  // random payload. A cut index at or above zero ends the chunk on that word
  // and abandons the rest of the frame; otherwise the whole frame goes out and
  // its final word carries the given chunk-end flag.
  task automatic send_frame(input logic [7:0] flags, input logic [6:0] code,
                            input logic [63:0] len, input logic [31:0] key,
                            input int cut, input logic tail_end);
    logic [7:0] head[$];
    int         ext_bytes;
    int         last;
    int         i;
    head.push_back(flags);
    // The mask bit of byte 1 is random: the block expects a key either way.
    head.push_back({1'($urandom_range(0, 1)), code});
    if (code == LenCode16) begin
      ext_bytes = int'(ExtBytes16);
      frames_ext16++;
    end else if (code > LenCodeMaxShort) begin
      ext_bytes = int'(ExtBytes64);
      frames_ext64++;
    end else begin
      ext_bytes = 0;
    end
    for (i = ext_bytes - 1; i >= 0; i--) head.push_back(len[8 * i +: 8]);
    for (i = 3; i >= 0; i--) head.push_back(key[8 * i +: 8]);
    last = (cut >= 0) ? cut : head.size() + int'(len) - 1;
    for (i = 0; i <= last; i++) begin
      send_word((i < head.size()) ? head[i] : 8'($urandom),
                (i == last) ? (cut >= 0 || tail_end) : 1'b0);
    end
    frames_sent++;
    if (cut >= 0) frames_cut++;
  endtask

  // A random frame. Most use the short length form with a few payload words;
  // the extended forms mix small lengths, lengths just past the short range and
  // huge lengths. Huge frames are always cut short, and about one frame in
  // eight is cut at a random word of its header or payload.
  task automatic send_random_frame();
    logic [63:0] len;
    logic [6:0]  code;
    int          head_len;
    int          pick;
    int          cut;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      case ($urandom_range(0, 9))
        0:       len = 64'd0;
        1:       len = 64'(LenCodeMaxShort);
        2:       len = 64'($urandom_range(0, 124));
        default: len = 64'($urandom_range(1, 8));
      endcase
      code     = len[6:0];
      head_len = 6;
    end else if (pick < 85) begin
      case ($urandom_range(0, 7))
        0:       len = 64'($urandom_range(126, 170));
        1:       len = 64'(16'($urandom));
        2:       len = 64'hFFFF;
        default: len = 64'($urandom_range(0, 10));
      endcase
      code     = LenCode16;
      head_len = 8;
    end else begin
      case ($urandom_range(0, 7))
        0:       len = {$urandom, $urandom};
        1:       len = '1;
        default: len = 64'($urandom_range(0, 12));
      endcase
      code     = LenCode64;
      head_len = 14;
    end
    if (len > 64'd200 || $urandom_range(0, 7) == 0) begin
      cut = $urandom_range(0, head_len + ((len > 64'd24) ? 24 : int'(len)) - 1);
    end else begin
      cut = -1;
    end
    // RSV1 (bit 6) stays clear here; it would halt the block for the rest of the run.
    send_frame(8'($urandom) & 8'hBF, code, len, $urandom, cut, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int i;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    // An empty continuation frame with an all-zero key, chunk ending on its
    // last mask byte: one empty result and no truncation.
    send_frame(8'h80, 7'd0, 64'd0, 32'h0000_0000, -1, 1'b1);
    // A close frame with one payload word, checking the close flag.
    send_frame(8'h88, 7'd1, 64'd1, 32'hFF00_A55A, -1, 1'b0);
    // The largest 64-bit length with an all-ones key, cut on the first payload
    // word: the truncation replaces the payload result.
    send_frame(8'h02, LenCode64, '1, 32'hFFFF_FFFF, 14, 1'b0);
    // RSV2, RSV3 and the largest opcode on a first header byte that ends its
    // chunk: a truncation carrying that opcode.
    send_frame(8'hBF, LenCode16, 64'd0, 32'h0, 0, 1'b0);

    // Random part.
    while (words_sent < RandomWords) send_random_frame();

    // RSV1 set on a first header byte that also ends its chunk: the error wins,
    // and the block must ignore everything after it.
    send_word(8'hC8, 1'b1);
    for (i = 0; i < 3; i++) send_word(8'($urandom), 1'($urandom_range(0, 1)));
    stream_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Run covered %0d stream words in %0d frames (%0d with 16-bit length,",
             words_sent, frames_sent, frames_ext16);
    $display("%0d with 64-bit length, %0d cut short); %0d result words checked.",
             frames_ext64, frames_cut, checked);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
